FILE: sv/bmh_pkg.sv
// shared types and constants of the binary min-heap
package bmh_pkg;

    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int ENTRY_W  = KEY_W + PAY_W;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [PAY_W-1:0] payload;
    } entry_t;

    // read address choice of the two store ports
    typedef enum logic [1:0] {
        RD_ROOT_LAST   = 2'd0,
        RD_PARENT      = 2'd1,
        RD_GRANDPARENT = 2'd2,
        RD_CHILDREN    = 2'd3
    } rd_sel_t;

    typedef struct packed {
        logic    accept;
        rd_sel_t rd_sel;
        logic    move_up;
        logic    del_load;
        logic    move_down;
        logic    write_final;
        logic    publish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_delete;
        logic full;
        logic empty;
        logic has_parent;
        logic up_swap;
        logic up_more;
        logic has_child;
        logic down_swap;
        logic out_busy;
    } dp_stat_t;

endpackage

FILE: sv/bmh_req_if.sv
// request channel: operation beats into the heap
interface bmh_req_if import bmh_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [KEY_W-1:0] new_key;
    logic signed [PAY_W-1:0] new_payload;

    modport source (output valid, output func, output new_key, output new_payload, input ready);
    modport sink   (input valid, input func, input new_key, input new_payload, output ready);
endinterface

FILE: sv/bmh_rsp_if.sv
// response channel: result beats out of the heap
interface bmh_rsp_if import bmh_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] out_key;
    logic signed [PAY_W-1:0] out_payload;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count;

    modport source (output valid, output out_key, output out_payload, output status,
                    output count, input ready);
    modport sink   (input valid, input out_key, input out_payload, input status,
                    input count, output ready);
endinterface

FILE: sv/bmh_ram.sv
// generic ram: one write port, two registered read ports
module bmh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: sv/bmh_datapath.sv
// heap datapath: index and entry registers, key compares, store and result registers
module bmh_datapath import bmh_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_func,
    input  logic signed [KEY_W-1:0] in_key,
    input  logic signed [PAY_W-1:0] in_payload,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [KEY_W-1:0] out_key,
    output logic signed [PAY_W-1:0] out_payload,
    output logic [STATUS_W-1:0]     out_status,
    output logic [COUNT_W-1:0]      out_count,
    input  ctrl_cmd_t               cmd,
    output dp_stat_t                stat
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int XW = IW + 1;
    localparam int AW = $clog2(CAPACITY);

    logic [IW-1:0] cnt_reg;
    logic [IW-1:0] pos_reg;
    entry_t        mov_reg;

    status_t                 res_status_reg;
    logic signed [KEY_W-1:0] res_key_reg;
    logic signed [PAY_W-1:0] res_pay_reg;

    logic                    out_valid_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic signed [PAY_W-1:0] out_pay_reg;
    status_t                 out_status_reg;
    logic [COUNT_W-1:0]      out_count_reg;

    logic [XW-1:0] pos_x, cnt_x, left_idx, right_idx, idx_a, idx_b, child_idx;
    logic [AW-1:0] raddr_a, raddr_b, waddr;
    logic [ENTRY_W-1:0] rdata_a, rdata_b, wdata;
    logic          we;
    entry_t        rd_a, rd_b, child;
    logic          pick_right;
    logic [IW+COUNT_W-1:0] cnt_ext;

    assign pos_x     = {1'b0, pos_reg};
    assign cnt_x     = {1'b0, cnt_reg};
    assign left_idx  = pos_x << 1;
    assign right_idx = left_idx + XW'(1);

    always_comb
    begin
        idx_a = left_idx;
        idx_b = right_idx;
        unique case (cmd.rd_sel)
            RD_ROOT_LAST:
            begin
                idx_a = XW'(1);
                idx_b = cnt_x;
            end
            RD_PARENT:      idx_a = pos_x >> 1;
            RD_GRANDPARENT: idx_a = pos_x >> 2;
            RD_CHILDREN:    idx_a = left_idx;
            default:        idx_a = left_idx;
        endcase
    end

    // heap index i lives at store address i-1
    assign raddr_a = AW'(idx_a - XW'(1));
    assign raddr_b = AW'(idx_b - XW'(1));

    assign rd_a = entry_t'(rdata_a);
    assign rd_b = entry_t'(rdata_b);

    // smaller child, left on a tie
    assign pick_right = (right_idx <= cnt_x) && (rd_a.key > rd_b.key);
    assign child      = pick_right ? rd_b : rd_a;
    assign child_idx  = pick_right ? right_idx : left_idx;

    always_comb
    begin
        we    = cmd.move_up | cmd.move_down | cmd.write_final;
        waddr = AW'(pos_x - XW'(1));
        if (cmd.move_up)
        begin
            wdata = rd_a;
        end
        else if (cmd.move_down)
        begin
            wdata = child;
        end
        else
        begin
            wdata = mov_reg;
        end
    end

    bmh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.accept && (in_func == OP_INSERT) && (cnt_reg != IW'(CAPACITY)))
        begin
            cnt_reg <= cnt_reg + IW'(1);
        end
        else if (cmd.del_load)
        begin
            cnt_reg <= cnt_reg - IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mov_reg     <= '{key: in_key, payload: in_payload};
            pos_reg     <= cnt_reg + IW'(1);
            res_key_reg <= '0;
            res_pay_reg <= '0;
            if (in_func == OP_INSERT)
            begin
                res_status_reg <= (cnt_reg == IW'(CAPACITY)) ? ST_FULL : ST_INSERTED;
            end
            else
            begin
                res_status_reg <= (cnt_reg == '0) ? ST_EMPTY : ST_REMOVED;
            end
        end
        else if (cmd.del_load)
        begin
            res_key_reg <= rd_a.key;
            res_pay_reg <= rd_a.payload;
            mov_reg     <= rd_b;
            pos_reg     <= IW'(1);
        end
        else if (cmd.move_up)
        begin
            pos_reg <= pos_reg >> 1;
        end
        else if (cmd.move_down)
        begin
            pos_reg <= child_idx[IW-1:0];
        end
    end

    // output register
    assign cnt_ext = {{COUNT_W{1'b0}}, cnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_key_reg    <= res_key_reg;
            out_pay_reg    <= res_pay_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= cnt_ext[COUNT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_pay_reg;
    assign out_status  = out_status_reg;
    assign out_count   = out_count_reg;

    always_comb
    begin
        stat.is_delete  = (in_func == OP_DELETE);
        stat.full       = (cnt_reg == IW'(CAPACITY));
        stat.empty      = (cnt_reg == '0);
        stat.has_parent = ((pos_x >> 1) != '0);
        stat.up_swap    = (rd_a.key > mov_reg.key);
        stat.up_more    = ((pos_x >> 2) != '0);
        stat.has_child  = (left_idx <= cnt_x);
        stat.down_swap  = (mov_reg.key > child.key);
        stat.out_busy   = out_valid_reg & ~out_ready;
    end

endmodule

FILE: sv/bmh_ctrl.sv
// heap controller: sequences insert and delete walks over the store
module bmh_ctrl import bmh_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_UP_RD    = 9'b000000010,
        S_UP_CMP   = 9'b000000100,
        S_DEL_RD   = 9'b000001000,
        S_DEL_LOAD = 9'b000010000,
        S_DN_RD    = 9'b000100000,
        S_DN_CMP   = 9'b001000000,
        S_WR_FINAL = 9'b010000000,
        S_RESULT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.rd_sel      = RD_CHILDREN;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.is_delete)
                    begin
                        state_next = stat.empty ? S_RESULT : S_DEL_RD;
                    end
                    else
                    begin
                        state_next = stat.full ? S_RESULT : S_UP_RD;
                    end
                end
            end
            S_UP_RD:
            begin
                cmd.rd_sel = RD_PARENT;
                state_next = stat.has_parent ? S_UP_CMP : S_WR_FINAL;
            end
            S_UP_CMP:
            begin
                // next parent is fetched ahead while this one is compared
                cmd.rd_sel = RD_GRANDPARENT;
                if (stat.up_swap)
                begin
                    cmd.move_up = 1'b1;
                    state_next  = stat.up_more ? S_UP_CMP : S_WR_FINAL;
                end
                else
                begin
                    state_next = S_WR_FINAL;
                end
            end
            S_DEL_RD:
            begin
                cmd.rd_sel = RD_ROOT_LAST;
                state_next = S_DEL_LOAD;
            end
            S_DEL_LOAD:
            begin
                cmd.del_load = 1'b1;
                state_next   = S_DN_RD;
            end
            S_DN_RD:
            begin
                cmd.rd_sel = RD_CHILDREN;
                state_next = stat.has_child ? S_DN_CMP : S_WR_FINAL;
            end
            S_DN_CMP:
            begin
                if (stat.down_swap)
                begin
                    cmd.move_down = 1'b1;
                    state_next    = S_DN_RD;
                end
                else
                begin
                    state_next = S_WR_FINAL;
                end
            end
            S_WR_FINAL:
            begin
                cmd.write_final = 1'b1;
                state_next      = S_RESULT;
            end
            S_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/binary_min_heap.sv
// top level of the binary min-heap priority queue
//
//   channel  dir  beat                                         taken when
//   req      in   func, new_key, new_payload                   req.valid && req.ready
//   rsp      out  out_key, out_payload, status, count          rsp.valid && rsp.ready
//
// one operation at a time; the store is a ram with one write and two
// registered read ports, and each heap level costs one read and one write.
// an insert climbs until it reaches the root or a compare stops it, at most
// log2 CAPACITY levels; a delete descends until it reaches a leaf or a
// compare stops it; a full insert or an empty delete goes straight to the
// result; a busy rsp stalls the publish of the result
// reset clears the entry count and the result valid; store contents are
// left as they are, only entries at or below the count are ever used
// a result waiting on rsp does not block the next request beat, which is
// worked on until its own result needs the output register
module binary_min_heap import bmh_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    bmh_req_if.sink    req,
    bmh_rsp_if.source  rsp
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer: decides each step of the sift walks
    bmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: store, moving entry, hole index, compares, output register
    bmh_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_func     (req.func),
        .in_key      (req.new_key),
        .in_payload  (req.new_payload),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_key     (rsp.out_key),
        .out_payload (rsp.out_payload),
        .out_status  (rsp.status),
        .out_count   (rsp.count),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

FILE: bench/tb_top.sv
// self-checking bench for binary_min_heap: heap predictor, bursty driver, stalling receiver, monitor
`timescale 1ns / 100ps

module tb_top;
    import bmh_pkg::*;

    localparam int CAP          = 256;
    localparam int CLK_HALF     = 4;
    localparam int RANDOM_OPS   = 650;
    localparam int TAIL_CYCLES  = 40;
    localparam int HOLDOFF_LEN  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    // one operation beat as the driver presents it
    typedef struct {
        op_t                     op;
        logic signed [KEY_W-1:0] key;
        logic signed [PAY_W-1:0] payload;
    } heap_op_t;

    // one result beat as the heap should return it
    typedef struct {
        logic signed [KEY_W-1:0] out_key;
        logic signed [PAY_W-1:0] out_payload;
        status_t                 status;
        logic [COUNT_W-1:0]      count;
    } heap_result_t;

    logic clk;
    logic rst_n;

    bmh_req_if req_ch ();
    bmh_rsp_if rsp_ch ();

    binary_min_heap #(
        .CAPACITY (CAP)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // operations waiting to be driven, results waiting to be seen
    heap_op_t     pending_ops[$];
    heap_result_t expected_results[$];

    // private copy of the heap, one-based like the block
    entry_t model_heap [0:CAP];
    int     model_count;

    int   cycle_cnt;
    int   mismatch_cnt;
    int   ops_accepted;
    logic req_taken;

    // ------------------------------------------------------------------
    // clock and cycle counter
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // ------------------------------------------------------------------
    // predictor: apply one accepted operation to the model heap and
    // return the result beat it must produce
    // ------------------------------------------------------------------
    function automatic heap_result_t heap_apply(heap_op_t item);
        heap_result_t            res;
        entry_t                  moving;
        logic signed [KEY_W-1:0] up_key;
        logic signed [KEY_W-1:0] pick_key;
        logic signed [KEY_W-1:0] right_key;
        int                      hole;
        int                      up;
        int                      pick;
        bit                      sifting;
        res.out_key     = '0;
        res.out_payload = '0;
        if (item.op == OP_INSERT)
        begin
            if (model_count >= CAP)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                // climb while the parent key is strictly larger
                model_count = model_count + 1;
                hole = model_count;
                up = hole / 2;
                sifting = 1'b1;
                while (sifting && up >= 1)
                begin
                    up_key = model_heap[up].key;
                    if (up_key > item.key)
                    begin
                        model_heap[hole] = model_heap[up];
                        hole = up;
                        up = up / 2;
                    end
                    else
                    begin
                        sifting = 1'b0;
                    end
                end
                model_heap[hole].key     = item.key;
                model_heap[hole].payload = item.payload;
                res.status = ST_INSERTED;
            end
        end
        else
        begin
            if (model_count < 1)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.out_key     = model_heap[1].key;
                res.out_payload = model_heap[1].payload;
                model_heap[1] = model_heap[model_count];
                model_count = model_count - 1;
                // descend toward the smaller child, left one on a tie
                moving = model_heap[1];
                hole = 1;
                sifting = 1'b1;
                while (sifting && 2 * hole <= model_count)
                begin
                    pick = 2 * hole;
                    pick_key = model_heap[pick].key;
                    if (pick + 1 <= model_count)
                    begin
                        right_key = model_heap[pick + 1].key;
                        if (pick_key > right_key)
                        begin
                            pick = pick + 1;
                            pick_key = right_key;
                        end
                    end
                    up_key = moving.key;
                    if (up_key > pick_key)
                    begin
                        model_heap[hole] = model_heap[pick];
                        hole = pick;
                    end
                    else
                    begin
                        sifting = 1'b0;
                    end
                end
                model_heap[hole] = moving;
                res.status = ST_REMOVED;
            end
        end
        res.count = model_count[COUNT_W-1:0];
        return res;
    endfunction

    // key and payload values: full range, clustered small values for ties,
    // 16-bit spread and the extremes
    function automatic logic signed [31:0] rand_word();
        logic signed [31:0] w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w = $urandom;
            4, 5, 6:    w = $signed($urandom_range(0, 15)) - 8;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       w = 32'sh7fffffff;
                    1:       w = 32'sh80000000;
                    2:       w = 32'sh0;
                    default: w = -32'sh1;
                endcase
            end
            default:    w = $signed($urandom_range(0, 65535)) - 32768;
        endcase
        return w;
    endfunction

    function automatic heap_op_t make_op(op_t op, logic signed [31:0] key,
                                         logic signed [31:0] payload);
        heap_op_t item;
        item.op      = op;
        item.key     = key;
        item.payload = payload;
        return item;
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of beats with random gaps, a beat is held until taken
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(negedge clk)
    begin
        heap_op_t item;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (req_ch.valid && !req_taken)
        begin
            // beat still on offer, keep it steady
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            req_ch.valid <= 1'b0;
        end
        else if (pending_ops.size() > 0)
        begin
            item = pending_ops.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.func        <= item.op;
            req_ch.new_key     <= item.key;
            req_ch.new_payload <= item.payload;
            if (burst_left <= 1)
            begin
                // a quarter of the bursts run back to back with no gap
                burst_left <= $urandom_range(1, 30);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end
            else
            begin
                burst_left <= burst_left - 1;
            end
        end
        else
        begin
            req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // long receiver hold-off, twice in the run, so the block backs up
    // and stalls its request side
    // ------------------------------------------------------------------
    int holdoff_left;
    int holdoff_idx;

    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
        end
        else if ((holdoff_idx == 0 && ops_accepted >= 60)
                 || (holdoff_idx == 1 && ops_accepted >= 500))
        begin
            holdoff_left <= HOLDOFF_LEN;
            holdoff_idx <= holdoff_idx + 1;
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern: a random mode, redrawn after a random count of cycles
    // ------------------------------------------------------------------
    int rx_mode;
    int rx_left;
    int rx_phase;

    always @(negedge clk)
    begin
        logic rdy;
        case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = $urandom_range(0, 1);
            2:       rdy = (rx_phase % 4 == 0);
            default: rdy = ($urandom_range(0, 9) != 0);
        endcase
        if (!rst_n || holdoff_left > 0)
        begin
            rdy = 1'b0;
        end
        rsp_ch.ready <= rdy;
        rx_phase <= rx_phase + 1;
        if (rx_left <= 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(10, 80);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on each request beat, check each result beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        heap_op_t     taken_op;
        heap_result_t want;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
        end
        else
        begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= REPORT_LIMIT)
                    begin
                        $display("unexpected result beat: key %0d payload %0d status %0d count %0d",
                                 rsp_ch.out_key, rsp_ch.out_payload, rsp_ch.status,
                                 rsp_ch.count);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.out_key !== want.out_key
                        || rsp_ch.out_payload !== want.out_payload
                        || rsp_ch.status !== want.status
                        || rsp_ch.count !== want.count)
                    begin
                        mismatch_cnt = mismatch_cnt + 1;
                        if (mismatch_cnt <= REPORT_LIMIT)
                        begin
                            $display("mismatch at cycle %0d: exp key %0d payload %0d status %0d count %0d, got key %0d payload %0d status %0d count %0d",
                                     cycle_cnt, want.out_key, want.out_payload,
                                     want.status, want.count, rsp_ch.out_key,
                                     rsp_ch.out_payload, rsp_ch.status, rsp_ch.count);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                taken_op.op      = op_t'(req_ch.func);
                taken_op.key     = req_ch.new_key;
                taken_op.payload = req_ch.new_payload;
                expected_results.push_back(heap_apply(taken_op));
                ops_accepted <= ops_accepted + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int   gen_count;
        int   n_random;
        int   n_mixed;
        int   i;
        op_t  op;

        // known levels on every input from time zero
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.func        = OP_INSERT;
        req_ch.new_key     = '0;
        req_ch.new_payload = '0;
        rsp_ch.ready       = 1'b0;
        cycle_cnt          = 0;
        mismatch_cnt       = 0;
        ops_accepted       = 0;
        burst_left         = 0;
        gap_left           = 0;
        holdoff_left       = 0;
        holdoff_idx        = 0;
        rx_mode            = 0;
        rx_left            = 0;
        rx_phase           = 0;
        model_count        = 0;
        for (i = 0; i <= CAP; i++)
        begin
            model_heap[i] = '0;
        end

        // directed: delete on empty, extreme keys and payloads, equal keys
        pending_ops.push_back(make_op(OP_DELETE, 32'sh0, 32'sh0));
        pending_ops.push_back(make_op(OP_INSERT, 32'sh7fffffff, 32'sh80000000));
        pending_ops.push_back(make_op(OP_INSERT, 32'sh80000000, 32'sh7fffffff));
        pending_ops.push_back(make_op(OP_INSERT, 32'sh0, 32'sh0));
        pending_ops.push_back(make_op(OP_INSERT, -32'sh1, -32'sh1));
        pending_ops.push_back(make_op(OP_INSERT, 32'sh0, 32'sh55555555));
        pending_ops.push_back(make_op(OP_INSERT, 32'sh0, 32'shaaaaaaaa));
        pending_ops.push_back(make_op(OP_INSERT, 32'sh7fffffff, 32'sh1));
        for (i = 0; i < 7; i++)
        begin
            pending_ops.push_back(make_op(OP_DELETE, 32'sh0, 32'sh0));
        end
        // delete on empty with junk in the ignored fields
        pending_ops.push_back(make_op(OP_DELETE, -32'sh1, -32'sh1));
        // two equal children under the root: the left one must win
        pending_ops.push_back(make_op(OP_INSERT, 32'sh1, 32'sh10));
        pending_ops.push_back(make_op(OP_INSERT, 32'sh3, 32'sh20));
        pending_ops.push_back(make_op(OP_INSERT, 32'sh3, 32'sh30));
        pending_ops.push_back(make_op(OP_INSERT, 32'sh9, 32'sh40));
        for (i = 0; i < 4; i++)
        begin
            pending_ops.push_back(make_op(OP_DELETE, 32'sh0, 32'sh0));
        end

        // random: fill to capacity and past it, drain to empty and past it,
        // then a mixed stretch
        gen_count = 0;
        n_random = 0;
        n_mixed = 0;
        while (gen_count < CAP)
        begin
            op = ($urandom_range(0, 9) < 9) ? OP_INSERT : OP_DELETE;
            pending_ops.push_back(make_op(op, rand_word(), rand_word()));
            gen_count = (op == OP_INSERT) ? gen_count + 1
                      : ((gen_count > 0) ? gen_count - 1 : 0);
            n_random++;
        end
        for (i = 0; i < 3; i++)
        begin
            pending_ops.push_back(make_op(OP_INSERT, rand_word(), rand_word()));
            n_random++;
        end
        while (gen_count > 0)
        begin
            op = ($urandom_range(0, 9) < 9) ? OP_DELETE : OP_INSERT;
            pending_ops.push_back(make_op(op, rand_word(), rand_word()));
            gen_count = (op == OP_DELETE) ? gen_count - 1
                      : ((gen_count < CAP) ? gen_count + 1 : gen_count);
            n_random++;
        end
        for (i = 0; i < 2; i++)
        begin
            pending_ops.push_back(make_op(OP_DELETE, rand_word(), rand_word()));
            n_random++;
        end
        while (n_random < RANDOM_OPS || n_mixed < 30)
        begin
            op = op_t'($urandom_range(0, 1));
            pending_ops.push_back(make_op(op, rand_word(), rand_word()));
            n_random++;
            n_mixed++;
        end

        // hold reset, then release it on a falling edge, away from the rising edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain: every beat sent, every result seen
        while (pending_ops.size() > 0 || req_ch.valid || expected_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && expected_results.size() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
